@@ design/irpps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpps_pkg
// Shared types and constants of the IR proximity pulse sequencer.
// ----------------------------------------------------------------------------
package irpps_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int HALF         = SENSOR_COUNT / 2;
  localparam int PAIR_W       = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int TICK_W       = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TICK = 1'b0,
    CFG_PULSE_TICK = 1'b1
  } irpps_cfg_e;

  // Capture controls of the word being accepted, fanned out to every lane.
  typedef struct packed {
    logic              fire;
    logic              cap_amb;
    logic              cap_ref;
    logic [PAIR_W-1:0] pair;
    logic              calib_clear;
    logic              calib_add;
  } irpps_cap_t;

  // Status of the word held in the capture stage.
  typedef struct packed {
    logic            valid;
    logic            done;
    logic            finish;
    logic            active;
    logic [HALF-1:0] led;
  } irpps_stat_t;

  // Controls of the output stage, common to all lanes.
  typedef struct packed {
    logic load;
    logic finish;
    logic active;
  } irpps_load_t;

endpackage

@@ design/irpps_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpps_seq
// Tick counter, pair selection, LED state and calibration pass control.
// ----------------------------------------------------------------------------
module irpps_seq
  import irpps_pkg::*;
#(
  parameter int CALIB_PASSES = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  fire_i,
  input  logic                  advance_i,
  input  logic                  start_calibration_i,
  output irpps_cap_t            cap_o,
  output irpps_stat_t           stat_o
);

  localparam int PASS_W = $clog2(CALIB_PASSES + 1);

  logic [TICK_W-1:0] start_q, pulse_q, tick_q;
  logic [PAIR_W-1:0] pair_q;
  logic [HALF-1:0]   led_q;
  logic [PASS_W-1:0] passes_q, passes_base, passes_inc;
  logic              active_q, active_base;
  logic              s1_valid_q, s1_done_q, s1_finish_q;
  logic [TICK_W-1:0] amb_at, ref_at;
  logic              is_amb, is_ref, last, done, add, finish;

  assign amb_at      = start_q - TICK_W'(1);
  assign ref_at      = pulse_q - TICK_W'(1);
  assign is_amb      = (tick_q == amb_at);
  assign is_ref      = !is_amb && (tick_q == ref_at);
  assign last        = (pair_q == PAIR_W'(HALF - 1));
  assign done        = is_ref && last;
  assign active_base = start_calibration_i || active_q;
  assign passes_base = start_calibration_i ? '0 : passes_q;
  assign passes_inc  = passes_base + PASS_W'(1);
  assign add         = done && active_base;
  assign finish      = add && (passes_inc >= PASS_W'(CALIB_PASSES));

  always_comb begin
    cap_o.fire        = fire_i;
    cap_o.cap_amb     = is_amb;
    cap_o.cap_ref     = is_ref;
    cap_o.pair        = pair_q;
    cap_o.calib_clear = start_calibration_i;
    cap_o.calib_add   = add;
    stat_o.valid      = s1_valid_q;
    stat_o.done       = s1_done_q;
    stat_o.finish     = s1_finish_q;
    stat_o.active     = active_q;
    stat_o.led        = led_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= TICK_W'(64);
      pulse_q <= TICK_W'(4);
    end else if (cfg_we_i) begin
      case (irpps_cfg_e'(cfg_index_i))
        CFG_START_TICK: start_q <= cfg_data_i;
        CFG_PULSE_TICK: pulse_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      pair_q      <= '0;
      led_q       <= '0;
      passes_q    <= '0;
      active_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_done_q   <= 1'b0;
      s1_finish_q <= 1'b0;
    end else begin
      if (fire_i) begin
        tick_q <= (tick_q >= start_q) ? '0 : tick_q + TICK_W'(1);
        if (is_amb) begin
          led_q <= led_q | (HALF'(1) << pair_q);
        end else if (is_ref) begin
          led_q  <= led_q & ~(HALF'(1) << pair_q);
          pair_q <= last ? '0 : pair_q + PAIR_W'(1);
        end
        passes_q    <= add ? passes_inc : passes_base;
        active_q    <= finish ? 1'b0 : active_base;
        s1_valid_q  <= 1'b1;
        s1_done_q   <= done;
        s1_finish_q <= finish;
      end else if (advance_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ design/irpps_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpps_lane
// One sensor: sample capture, ambient subtraction, offset sum and level.
// ----------------------------------------------------------------------------
module irpps_lane
  import irpps_pkg::*;
#(
  parameter int LANE         = 0,
  parameter int CALIB_PASSES = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  irpps_cap_t             cap_i,
  input  irpps_load_t            load_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] level_o
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(CALIB_PASSES + 1);
  localparam int DIV_SH  = SUM_W + $clog2(CALIB_PASSES);
  localparam int RECIP_I = ((1 << DIV_SH) + CALIB_PASSES - 1) / CALIB_PASSES;
  localparam logic [DIV_SH:0]   RECIP = (DIV_SH + 1)'(RECIP_I);
  localparam logic [PAIR_W-1:0] PAIR  = PAIR_W'(LANE % HALF);

  logic [SAMPLE_BITS-1:0] amb_q, ref_q, off_q, level_q;
  logic [SAMPLE_BITS-1:0] amb_d, ref_d, raw_d, raw_now, quot, off_sel;
  logic [SUM_W-1:0]       sum_q, sum_base;
  logic [SUM_W+DIV_SH:0]  prod;
  logic                   hit;

  assign hit      = cap_i.fire && (cap_i.pair == PAIR);
  assign amb_d    = (hit && cap_i.cap_amb) ? sample_i : amb_q;
  assign ref_d    = (hit && cap_i.cap_ref) ? sample_i : ref_q;
  assign raw_d    = (amb_d > ref_d) ? amb_d - ref_d : '0;
  assign sum_base = cap_i.calib_clear ? '0 : sum_q;

  // Division by the pass count as a reciprocal multiply; the shift is wide
  // enough that the quotient is exact over the whole sum range.
  assign prod    = {{(DIV_SH + 1){1'b0}}, sum_q} * {{SUM_W{1'b0}}, RECIP};
  assign quot    = prod[DIV_SH +: SAMPLE_BITS];
  assign raw_now = (amb_q > ref_q) ? amb_q - ref_q : '0;
  assign off_sel = load_i.active ? '0 : (load_i.finish ? quot : off_q);
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q <= '0;
      ref_q <= '0;
      sum_q <= '0;
      off_q <= '0;
    end else begin
      if (cap_i.fire) begin
        amb_q <= amb_d;
        ref_q <= ref_d;
        sum_q <= cap_i.calib_add ? sum_base + SUM_W'(raw_d) : sum_base;
      end
      if (load_i.load && load_i.finish) begin
        off_q <= quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      level_q <= (raw_now > off_sel) ? raw_now - off_sel : '0;
    end
  end

endmodule

@@ design/ir_proximity_pulse_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_proximity_pulse_sequencer_unit
// Pulsed IR proximity sequencer with ambient subtraction and calibration.
// ----------------------------------------------------------------------------
// Usage: each input word is one ADC scan event with eight sensor samples and
// a calibration request bit. A word is taken on a rising edge where
// in_valid_i is high and in_stall_o is low; a result word leaves on an edge
// where out_valid_o is high and out_stall_i is low. Every input word gives
// exactly one result word: the LED mask, the pass-complete flag, the
// calibration flag and eight offset-corrected levels.
// A word passes through the capture stage and then the output register.
// Throughput is one word per cycle while the receiver does not stall: the
// capture stage and the output register form a two stage pipeline, so a
// new word is taken while a result waits.
// If the receiver stalls, the output register holds its word and the
// capture stage holds the next one; only then is in_stall_o raised.
// The start_tick and pulse_tick registers are written through the cfg port
// while the block is idle; this binds the user and the block does not enforce
// it. Reset clears the tick counter, pair index, LEDs, stored samples,
// offsets and calibration state; it loads start_tick = 64 and pulse_tick = 4.
// Eight sensor lanes work side by side; the top level merges their levels
// with the sequencer status into the output register.
module ir_proximity_pulse_sequencer_unit
  import irpps_pkg::*;
#(
  parameter int CALIB_PASSES = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_0_i,
  input  logic [SAMPLE_BITS-1:0] sample_1_i,
  input  logic [SAMPLE_BITS-1:0] sample_2_i,
  input  logic [SAMPLE_BITS-1:0] sample_3_i,
  input  logic [SAMPLE_BITS-1:0] sample_4_i,
  input  logic [SAMPLE_BITS-1:0] sample_5_i,
  input  logic [SAMPLE_BITS-1:0] sample_6_i,
  input  logic [SAMPLE_BITS-1:0] sample_7_i,
  input  logic                   start_calibration_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [HALF-1:0]        led_mask_o,
  output logic                   pass_done_o,
  output logic                   calibrating_o,
  output logic [SAMPLE_BITS-1:0] level_0_o,
  output logic [SAMPLE_BITS-1:0] level_1_o,
  output logic [SAMPLE_BITS-1:0] level_2_o,
  output logic [SAMPLE_BITS-1:0] level_3_o,
  output logic [SAMPLE_BITS-1:0] level_4_o,
  output logic [SAMPLE_BITS-1:0] level_5_o,
  output logic [SAMPLE_BITS-1:0] level_6_o,
  output logic [SAMPLE_BITS-1:0] level_7_o
);

  irpps_cap_t             cap;
  irpps_stat_t            stat;
  irpps_load_t            load;
  logic                   fire, advance;
  logic                   out_valid_q;
  logic [HALF-1:0]        led_q;
  logic                   done_q, calib_q;
  logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] levels  [SENSOR_COUNT];

  // The capture stage moves on when the output register is empty or is
  // being emptied this cycle. Input is held off only when both are full.
  assign advance    = stat.valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stat.valid && !advance;
  assign fire       = in_valid_i && !in_stall_o;

  always_comb begin
    load.load   = advance;
    load.finish = stat.finish;
    load.active = stat.active;
  end

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  irpps_seq #(
    .CALIB_PASSES(CALIB_PASSES)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fire_i             (fire),
    .advance_i          (advance),
    .start_calibration_i(start_calibration_i),
    .cap_o              (cap),
    .stat_o             (stat)
  );

  for (genvar k = 0; k < SENSOR_COUNT; k++) begin : g_lane
    irpps_lane #(
      .LANE        (k),
      .CALIB_PASSES(CALIB_PASSES)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cap_i   (cap),
      .load_i  (load),
      .sample_i(samples[k]),
      .level_o (levels[k])
    );
  end

  // Output register: valid is control, the status fields are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      led_q   <= stat.led;
      done_q  <= stat.done;
      calib_q <= stat.active;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_mask_o    = led_q;
  assign pass_done_o   = done_q;
  assign calibrating_o = calib_q;
  assign level_0_o     = levels[0];
  assign level_1_o     = levels[1];
  assign level_2_o     = levels[2];
  assign level_3_o     = levels[3];
  assign level_4_o     = levels[4];
  assign level_5_o     = levels[5];
  assign level_6_o     = levels[6];
  assign level_7_o     = levels[7];

  // Only the current pair's LED can be lit.
  a_led_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(led_mask_o))
    else $error("more than one LED pair lit");

  // Input is held off only behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A finished calibration coincides with a completed pass and ends it.
  a_finish_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.valid && stat.finish) |-> (stat.done && !stat.active))
    else $error("calibration finished outside a pass completion");

  // Every result carries the pass-complete flag of its word to the output.
  a_calib_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && (pass_done_o == $past(stat.done))))
    else $error("pass flag lost on its way to the output");

endmodule
